FILE: hdl/jsec_pkg.sv
// types, microcode table and helper functions for the json string escaper with crc-32
package jsec_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 32;
  localparam int unsigned PcW   = 3;

  localparam logic [CrcW-1:0]  CrcSeed = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 32'hEDB8_8320;
  localparam logic [ByteW-1:0] CtrlLimit = 8'h20;

  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChU      = 8'h75;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;

  // program entry points and jump target
  localparam logic [PcW-1:0] EntryPass = 3'd0;
  localparam logic [PcW-1:0] EntryEsc  = 3'd1;
  localparam logic [PcW-1:0] TgtUni    = 3'd3;

  typedef enum logic [2:0] {
    SRC_RAW,
    SRC_BSLASH,
    SRC_LETTER,
    SRC_U,
    SRC_ZERO,
    SRC_HEX_HI,
    SRC_HEX_LO
  } src_e;

  typedef struct packed {
    src_e src;      // which byte the datapath emits
    logic last;     // final step of this item
    logic jmp_uni;  // jump to the unicode escape when the byte needs one
  } uword_t;

  // microcode: pass-through, two-byte escape, six-byte unicode escape
  function automatic uword_t urom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{src: SRC_RAW, last: 1'b1, jmp_uni: 1'b0};
    case (pc)
      3'd0:    w = '{src: SRC_RAW,    last: 1'b1, jmp_uni: 1'b0};
      3'd1:    w = '{src: SRC_BSLASH, last: 1'b0, jmp_uni: 1'b1};
      3'd2:    w = '{src: SRC_LETTER, last: 1'b1, jmp_uni: 1'b0};
      3'd3:    w = '{src: SRC_U,      last: 1'b0, jmp_uni: 1'b0};
      3'd4:    w = '{src: SRC_ZERO,   last: 1'b0, jmp_uni: 1'b0};
      3'd5:    w = '{src: SRC_ZERO,   last: 1'b0, jmp_uni: 1'b0};
      3'd6:    w = '{src: SRC_HEX_HI, last: 1'b0, jmp_uni: 1'b0};
      3'd7:    w = '{src: SRC_HEX_LO, last: 1'b1, jmp_uni: 1'b0};
      default: w = '{src: SRC_RAW,    last: 1'b1, jmp_uni: 1'b0};
    endcase
    return w;
  endfunction

  // second byte of a short escape, zero when the byte has none
  function automatic logic [ByteW-1:0] esc_letter(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] l;
    l = '0;
    case (b)
      8'h22:   l = ChQuote;
      8'h5C:   l = ChBslash;
      8'h08:   l = 8'h62;
      8'h0C:   l = 8'h66;
      8'h0A:   l = 8'h6E;
      8'h0D:   l = 8'h72;
      8'h09:   l = 8'h74;
      default: l = '0;
    endcase
    return l;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n);
    logic [ByteW-1:0] c;
    if (n < 4'd10) begin
      c = ChZero + {4'd0, n};
    end else begin
      c = 8'h37 + {4'd0, n};
    end
    return c;
  endfunction

  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] c_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/json_string_escape_crc32.sv
// json string escaper with running crc-32, one microcode step per output byte
// first output byte is registered by the first microcode step after the item is accepted
// a new item is taken only after the last one's n = 1, 2 or 6 output bytes, the microcode
// step counter emitting one byte (and one crc fold) per cycle while the output is not stalled
// reset: asynchronous active low, crc accumulator seeded to all ones, sequencer idle
module json_string_escape_crc32 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_string_i,
  input  logic       msg_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       crc_valid_o,
  output logic [31:0] crc_value_o
);

  logic                          busy_q;
  logic [jsec_pkg::PcW-1:0]      pc_q, pc_d;
  logic [jsec_pkg::ByteW-1:0]    byte_q;
  logic                          uni_q;
  logic                          mlast_q;
  logic [jsec_pkg::CrcW-1:0]     crc_q, crc_d;
  logic                          out_valid_q, out_valid_d;
  logic [jsec_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  logic                          run_last_q;
  logic                          crc_valid_q;
  logic [jsec_pkg::CrcW-1:0]     crc_value_q, crc_value_d;

  jsec_pkg::uword_t              uw;
  logic [jsec_pkg::ByteW-1:0]    letter_d, letter_q;
  logic                          accept, emit;
  logic                          is_short, is_uni;

  assign accept = in_valid_i && in_ready_o;
  assign emit   = busy_q && (!out_valid_q || out_ready_i);
  assign uw     = jsec_pkg::urom(pc_q);

  assign letter_d = jsec_pkg::esc_letter(in_byte_i);
  assign is_short = in_string_i && (letter_d != '0);
  assign is_uni   = in_string_i && (letter_d == '0) && (in_byte_i < jsec_pkg::CtrlLimit);

  // datapath byte select
  always_comb begin
    case (uw.src)
      jsec_pkg::SRC_RAW:    out_byte_d = byte_q;
      jsec_pkg::SRC_BSLASH: out_byte_d = jsec_pkg::ChBslash;
      jsec_pkg::SRC_LETTER: out_byte_d = letter_q;
      jsec_pkg::SRC_U:      out_byte_d = jsec_pkg::ChU;
      jsec_pkg::SRC_ZERO:   out_byte_d = jsec_pkg::ChZero;
      jsec_pkg::SRC_HEX_HI: out_byte_d = jsec_pkg::hex_char(byte_q[7:4]);
      jsec_pkg::SRC_HEX_LO: out_byte_d = jsec_pkg::hex_char(byte_q[3:0]);
      default:              out_byte_d = byte_q;
    endcase
  end

  always_comb begin
    crc_d       = jsec_pkg::crc_fold(crc_q, out_byte_d);
    crc_value_d = '0;
    if (uw.last && mlast_q) begin
      crc_value_d = ~crc_d;
    end
    pc_d = pc_q + 1'b1;
    if (uw.jmp_uni && uni_q) begin
      pc_d = jsec_pkg::TgtUni;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= jsec_pkg::EntryPass;
      crc_q       <= jsec_pkg::CrcSeed;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= (is_short || is_uni) ? jsec_pkg::EntryEsc : jsec_pkg::EntryPass;
      end else if (emit) begin
        pc_q        <= pc_d;
        // reseed once the message's final byte is folded
        crc_q       <= (uw.last && mlast_q) ? jsec_pkg::CrcSeed : crc_d;
        if (uw.last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q   <= in_byte_i;
      letter_q <= letter_d;
      uni_q    <= is_uni;
      mlast_q  <= msg_last_i;
    end
    if (emit) begin
      out_byte_q  <= out_byte_d;
      run_last_q  <= uw.last;
      crc_valid_q <= uw.last && mlast_q;
      crc_value_q <= crc_value_d;
    end
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign crc_valid_o = crc_valid_q;
  assign crc_value_o = crc_value_q;

`ifndef ASSERT_OFF
  a_crc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_valid_o |-> run_last_o)
    else $error("crc reported on a byte that does not end its item");

  a_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !crc_valid_o |-> crc_value_o == '0)
    else $error("crc value nonzero without crc_valid");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && (pc_q == jsec_pkg::EntryPass || pc_q == jsec_pkg::EntryEsc))
    else $error("sequencer did not start at an entry point");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && uw.last |=> !busy_q)
    else $error("sequencer still busy after final step");

  a_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && uw.last && mlast_q |=> crc_q == jsec_pkg::CrcSeed)
    else $error("crc not reseeded after message end");
`endif

endmodule

FILE: verif/json_string_escape_crc32_test.sv
// self-checking testbench for the json string escaper with running crc-32
module json_string_escape_crc32_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] CrcSeed = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // control bytes with a short escape and the letter that follows the backslash
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] LetterB     = 8'h62;
  localparam logic [7:0] LetterF     = 8'h66;
  localparam logic [7:0] LetterN     = 8'h6E;
  localparam logic [7:0] LetterR     = 8'h72;
  localparam logic [7:0] LetterT     = 8'h74;

  localparam logic [7:0] HexAscii [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  localparam logic [7:0] ShortEscBytes [7] = '{
    jsec_pkg::ChQuote, jsec_pkg::ChBslash, ChBackspace, ChFormFeed,
    ChNewline, ChReturn, ChTab
  };

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned ChokeCycles = 150;
  localparam int unsigned RandomItems = 100;
  localparam int unsigned CalmItems = 80;

  typedef struct packed {
    logic [7:0]  data;
    logic        run_end;
    logic        sum_valid;
    logic [31:0] sum;
  } escaped_t;

  // directed row: input item plus, where obvious, the crc of a one-byte message
  typedef struct packed {
    logic [7:0]  data;
    logic        in_str;
    logic        last;
    logic        known;
    logic [31:0] known_crc;
  } dir_row_t;

  localparam int unsigned NumRows = 22;
  localparam dir_row_t DirRows [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'hD202_EF8D},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 32'hFF00_0000},
    '{8'h22, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h5C, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h08, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h0C, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h0A, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h0D, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h09, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h1F, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h10, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h1A, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h20, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h22, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h5C, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h1F, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        in_string_i;
  logic        msg_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        crc_valid_o;
  logic [31:0] crc_value_o;

  escaped_t    pending_q [$];
  logic [31:0] running_crc;
  int unsigned items_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          calm;
  bit          choke_done;

  json_string_escape_crc32 i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_string_i(in_string_i),
    .msg_last_i (msg_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .crc_valid_o(crc_valid_o),
    .crc_value_o(crc_value_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] crc_absorb(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] short_letter(input logic [7:0] b);
    logic [7:0] l;
    case (b)
      jsec_pkg::ChQuote:  l = jsec_pkg::ChQuote;
      jsec_pkg::ChBslash: l = jsec_pkg::ChBslash;
      ChBackspace:        l = LetterB;
      ChFormFeed:         l = LetterF;
      ChNewline:          l = LetterN;
      ChReturn:           l = LetterR;
      ChTab:              l = LetterT;
      default:            l = 8'h00;
    endcase
    return l;
  endfunction

  // expand one item into its output bytes, fold them into the crc, queue them
  task automatic predict_escape(input logic [7:0] b, input logic in_str, input logic last);
    logic [7:0]  seq [6];
    int unsigned n;
    escaped_t    r;
    n = 1;
    seq[0] = b;
    if (in_str && short_letter(b) != 8'h00) begin
      seq[0] = jsec_pkg::ChBslash;
      seq[1] = short_letter(b);
      n = 2;
    end else if (in_str && b < jsec_pkg::CtrlLimit) begin
      seq[0] = jsec_pkg::ChBslash;
      seq[1] = jsec_pkg::ChU;
      seq[2] = jsec_pkg::ChZero;
      seq[3] = jsec_pkg::ChZero;
      seq[4] = HexAscii[b[7:4]];
      seq[5] = HexAscii[b[3:0]];
      n = 6;
    end
    for (int k = 0; k < n; k++) begin
      running_crc = crc_absorb(running_crc, seq[k]);
      r.data      = seq[k];
      r.run_end   = (k == n - 1);
      r.sum_valid = (k == n - 1) && last;
      r.sum       = r.sum_valid ? (running_crc ^ CrcSeed) : 32'h0;
      pending_q.push_back(r);
    end
    if (last) begin
      running_crc = CrcSeed;
    end
  endtask

  task automatic offer_item(input dir_row_t row);
    escaped_t known_r;
    in_valid_i  <= 1'b1;
    in_byte_i   <= row.data;
    in_string_i <= row.in_str;
    msg_last_i  <= row.last;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    items_taken++;
    predict_escape(row.data, row.in_str, row.last);
    if (row.known) begin
      // one-byte message straight after reseed: checksum typed in
      void'(pending_q.pop_back());
      known_r = '{data: row.data, run_end: 1'b1, sum_valid: 1'b1, sum: row.known_crc};
      pending_q.push_back(known_r);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // output side: check each output byte taken, watch for a hang
  always @(negedge clk_i) begin
    escaped_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected item: byte %h run_last %b crc_valid %b crc %h",
                     out_byte_o, run_last_o, crc_valid_o, crc_value_o);
          end
        end else begin
          e = pending_q.pop_front();
          if (out_byte_o !== e.data || run_last_o !== e.run_end ||
              crc_valid_o !== e.sum_valid || crc_value_o !== e.sum) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("exp byte %h run_last %b crc_valid %b crc %h",
                       e.data, e.run_end, e.sum_valid, e.sum);
              $display("got byte %h run_last %b crc_valid %b crc %h",
                       out_byte_o, run_last_o, crc_valid_o, crc_value_o);
            end
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the input
  initial begin : drain
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!choke_done && items_taken >= 40) begin
        choke_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (ChokeCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    int unsigned msg_len;
    int unsigned sent;
    running_crc  = CrcSeed;
    items_taken  = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    choke_done   = 1'b0;
    sent         = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= 8'h00;
    in_string_i <= 1'b0;
    msg_last_i  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      offer_item(DirRows[i]);
    end

    // random messages, control and quote bytes weighted up
    while (sent < RandomItems) begin
      msg_len = $urandom_range(1, 8);
      for (int i = 0; i < msg_len; i++) begin
        case ($urandom_range(0, 3))
          0:       row.data = 8'($urandom_range(0, 31));
          1:       row.data = ShortEscBytes[$urandom_range(0, 6)];
          default: row.data = 8'($urandom_range(0, 255));
        endcase
        row.in_str    = ($urandom_range(0, 9) < 7);
        row.last      = (i == msg_len - 1);
        row.known     = 1'b0;
        row.known_crc = 32'h0;
        calm = (sent >= CalmItems);
        offer_item(row);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
